[src/jsq_pkg.sv]
// Shared types and constants for the job slot queue engine.
// Used by every module under src except jsq_ram; depends on nothing.
`default_nettype none

package jsq_pkg;

  // Table geometry
  localparam int SLOT_COUNT = 64;
  localparam int KEY_BITS   = 32;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int SLOT_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int FMT_W      = 8;
  localparam int SRC_W      = 32;
  localparam int KEY_W      = (KEY_BITS < SRC_W) ? KEY_BITS : SRC_W;
  localparam int ENTRY_W    = KEY_W + FMT_W;

  // Link entry: top bit set means no successor
  localparam int LINK_W = IDX_W + 1;
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(1) << IDX_W;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_TAKE   = 2'd1,
    OP_FINISH = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_SCAN,
    S_ADD_WRITE,
    S_TAKE_WAIT,
    S_LOOK_SCAN,
    S_LOOK_LAST,
    S_RESULT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load_input;
    logic    step_idx;
    logic    tail_link;
    logic    add_write;
    logic    take_commit;
    logic    finish_clear;
    logic    look_read;
    logic    set_status;
    status_t status_val;
    logic    out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic free_none;
    logic free_hit;
    logic wait_empty;
    logic idx_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[src/job_slot_queue_engine.sv]
// Job slot queue engine: a 64-slot job table with a linked FIFO of waiting
// slots, a bitmap of working slots and a key lookup over all occupied slots.
// One item is handled at a time. After acceptance an item passes through
// decode, then: finish and rejected add or take go straight to the result;
// take reads the head's link RAM entry before it answers; add steps a slot
// counter to the lowest free slot, one slot per cycle, so its time depends on
// where that slot lies; lookup reads the key RAM once per slot through its
// single read port. The next item is accepted after the result is registered,
// while that result may still wait for the receiver. No clearing pass follows
// reset.
`default_nettype none

module job_slot_queue_engine import jsq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          operation,
  input  wire logic [SRC_W-1:0]    source_key,
  input  wire logic [FMT_W-1:0]    output_format,
  input  wire logic [SLOT_W-1:0]   slot,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic [SLOT_W-1:0]        slot_index,
  output logic [COUNT_W-1:0]       match_count,
  output logic                     duplicate,
  output logic [COUNT_W-1:0]       waiting_count,
  output logic                     overlap_error
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  jsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table storage and result register
  jsq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (operation),
    .source_key    (source_key),
    .output_format (output_format),
    .slot          (slot),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .slot_index    (slot_index),
    .match_count   (match_count),
    .duplicate     (duplicate),
    .waiting_count (waiting_count),
    .overlap_error (overlap_error)
  );

endmodule

`default_nettype wire

[src/jsq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module jsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[src/jsq_ctrl.sv]
// Controller state machine for the job slot queue engine.
// Depends on jsq_pkg; drives the datapath through cmd_t, reads stat_t.
`default_nettype none

module jsq_ctrl import jsq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.status_val = ST_DONE;
    in_stall       = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_input = 1'b1;
          state_next     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op)
          OP_ADD: begin
            if (stat.free_none) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ST_FULL;
              state_next     = S_RESULT;
            end else begin
              state_next = S_ADD_SCAN;
            end
          end
          OP_TAKE: begin
            if (stat.wait_empty) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ST_EMPTY;
              state_next     = S_RESULT;
            end else begin
              state_next = S_TAKE_WAIT;
            end
          end
          OP_FINISH: begin
            cmd.finish_clear = 1'b1;
            state_next       = S_RESULT;
          end
          OP_LOOKUP: begin
            state_next = S_LOOK_SCAN;
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_ADD_SCAN: begin
        // hold the index on the first free slot, link it behind the tail if any slot waits
        if (stat.free_hit) begin
          cmd.tail_link = !stat.wait_empty;
          state_next    = S_ADD_WRITE;
        end else begin
          cmd.step_idx = 1'b1;
        end
      end
      S_ADD_WRITE: begin
        cmd.add_write = 1'b1;
        state_next    = S_RESULT;
      end
      S_TAKE_WAIT: begin
        cmd.take_commit = 1'b1;
        state_next      = S_RESULT;
      end
      S_LOOK_SCAN: begin
        cmd.look_read = 1'b1;
        cmd.step_idx  = 1'b1;
        if (stat.idx_last) begin
          state_next = S_LOOK_LAST;
        end
      end
      S_LOOK_LAST: begin
        // last compare completes this cycle
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[src/jsq_datapath.sv]
// Datapath: slot bitmaps, queue pointers, key and link RAMs, result register.
// Depends on jsq_pkg and jsq_ram; steered by jsq_ctrl through cmd_t.
`default_nettype none

module jsq_datapath import jsq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output stat_t                    stat,
  input  wire logic [1:0]          operation,
  input  wire logic [SRC_W-1:0]    source_key,
  input  wire logic [FMT_W-1:0]    output_format,
  input  wire logic [SLOT_W-1:0]   slot,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic [SLOT_W-1:0]        slot_index,
  output logic [COUNT_W-1:0]       match_count,
  output logic                     duplicate,
  output logic [COUNT_W-1:0]       waiting_count,
  output logic                     overlap_error
);

  // Control state
  logic [SLOT_COUNT-1:0] waiting_map, waiting_map_next;
  logic [SLOT_COUNT-1:0] working_map, working_map_next;
  logic [IDX_W-1:0]      head_slot, tail_slot;
  logic [COUNT_W-1:0]    wcount;
  logic                  cmp_pending;

  // Per-item payload
  op_t                   op;
  logic [KEY_W-1:0]      key;
  logic [FMT_W-1:0]      fmt;
  logic [SLOT_W-1:0]     sel;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      cmp_slot;
  status_t               res_status;
  logic [SLOT_W-1:0]     res_index;
  logic [COUNT_W-1:0]    mcount;

  // RAM ports
  logic [ENTRY_W-1:0]    entry_rd;
  logic                  link_wr_en;
  logic [IDX_W-1:0]      link_wr_addr;
  logic [LINK_W-1:0]     link_wr_data;
  logic [LINK_W-1:0]     link_rd;

  logic [SLOT_COUNT-1:0] free_map, used_map;
  logic                  sel_in_range;
  logic [IDX_W-1:0]      sel_idx;
  logic                  hit;

  assign free_map     = ~(waiting_map | working_map);
  assign used_map     = waiting_map | working_map;
  assign sel_in_range = {1'b0, sel} < COUNT_W'(SLOT_COUNT);
  assign sel_idx      = sel[IDX_W-1:0];

  // Key and format store, read by the lookup scan
  jsq_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_entry_ram (
    .clk     (clk),
    .wr_en   (cmd.add_write),
    .wr_addr (idx),
    .wr_data ({key, fmt}),
    .rd_addr (idx),
    .rd_data (entry_rd)
  );

  // Successor links; the head's entry is read for a take
  always_comb begin
    link_wr_en   = cmd.tail_link | cmd.add_write;
    link_wr_addr = cmd.tail_link ? tail_slot : idx;
    link_wr_data = cmd.tail_link ? {1'b0, idx} : LINK_NONE;
  end

  jsq_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_COUNT)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_addr (head_slot),
    .rd_data (link_rd)
  );

  // Compare the entry read on the previous cycle
  assign hit = cmp_pending && used_map[cmp_slot] && (entry_rd == {key, fmt});

  // Bitmap updates
  always_comb begin
    waiting_map_next = waiting_map;
    working_map_next = working_map;
    if (cmd.add_write) begin
      waiting_map_next[idx] = 1'b1;
    end
    if (cmd.take_commit) begin
      waiting_map_next[head_slot] = 1'b0;
      working_map_next[head_slot] = 1'b1;
    end
    if (cmd.finish_clear && sel_in_range) begin
      working_map_next[sel_idx] = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting_map <= '0;
      working_map <= '0;
      head_slot   <= '0;
      tail_slot   <= '0;
      wcount      <= '0;
      cmp_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      waiting_map <= waiting_map_next;
      working_map <= working_map_next;
      cmp_pending <= cmd.look_read;
      if (cmd.add_write) begin
        tail_slot <= idx;
        if (waiting_map == '0) begin
          head_slot <= idx;
        end
      end
      if (cmd.take_commit && !link_rd[IDX_W]) begin
        head_slot <= link_rd[IDX_W-1:0];
      end
      // count waiting slots alongside the bitmap
      if (cmd.add_write) begin
        wcount <= wcount + COUNT_W'(1);
      end else if (cmd.take_commit) begin
        wcount <= wcount - COUNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item payload and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      op         <= op_t'(operation);
      key        <= source_key[KEY_W-1:0];
      fmt        <= output_format;
      sel        <= slot;
      idx        <= '0;
      res_status <= ST_DONE;
      res_index  <= '0;
      mcount     <= '0;
    end else begin
      if (cmd.step_idx) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.set_status) begin
        res_status <= cmd.status_val;
      end
      if (cmd.add_write) begin
        res_index <= SLOT_W'(idx);
      end
      if (cmd.take_commit) begin
        res_index <= SLOT_W'(head_slot);
      end
      if (cmd.finish_clear) begin
        res_index <= sel;
      end
      if (hit) begin
        res_index <= SLOT_W'(cmp_slot);
        mcount    <= mcount + COUNT_W'(1);
      end
    end
    cmp_slot <= idx;
  end

  // Result register, held while stalled
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status        <= res_status;
      slot_index    <= res_index;
      match_count   <= mcount;
      duplicate     <= mcount > COUNT_W'(1);
      waiting_count <= wcount;
      overlap_error <= |(waiting_map & working_map);
    end
  end

  // Status to the controller
  always_comb begin
    stat.op         = op;
    stat.free_none  = (free_map == '0);
    stat.free_hit   = free_map[idx];
    stat.wait_empty = (waiting_map == '0);
    stat.idx_last   = (idx == IDX_W'(SLOT_COUNT - 1));
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire
